>>> hw/rtl/tspm_pkg.sv
package tspm_pkg;

  typedef logic signed [19:0] height_t;
  typedef logic [23:0]        slope_t;
  typedef logic [19:0]        diff_t;
  typedef logic [10:0]        dim_t;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // widest scaled value: 6 * (2^20 - 1) stays below 2^23
  localparam int SCALED_W     = 23;
  localparam int SLOPE_FACTOR = 6;
  localparam slope_t SLOPE_MIN = 24'd16;

  localparam dim_t    MAP_WIDTH_RST   = 11'd256;
  localparam dim_t    MAP_HEIGHT_RST  = 11'd256;
  localparam slope_t  SLOPE_LIMIT_RST = 24'd400;
  localparam height_t MIN_DEPTH_RST   = -20'sd160000;
  localparam height_t MAX_DEPTH_RST   = 20'sd320;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH   = 3'd0,
    REG_MAP_HEIGHT  = 3'd1,
    REG_SLOPE_LIMIT = 3'd2,
    REG_MIN_DEPTH   = 3'd3,
    REG_MAX_DEPTH   = 3'd4
  } reg_idx_t;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_FLUSH  = 1'b1
  } mode_t;

  typedef struct packed {
    dim_t    map_width;
    dim_t    map_height;
    slope_t  slope_limit;
    height_t min_depth;
    height_t max_depth;
  } cfg_t;

  // per-cell control carried from the counter stage to the datapath
  typedef struct packed {
    logic    emit;
    logic    wr_mid;
    logic    has_left;
    logic    has_right;
    logic    has_up;
    logic    has_down;
    logic    border;
    logic    last;
    height_t down;
  } cell_ctl_t;

  typedef struct packed {
    logic last_fire;
    logic map_start;
  } ctl_stat_t;

  function automatic diff_t abs_diff(height_t a, height_t b);
    logic signed [20:0] d;
    d = $signed({a[19], a}) - $signed({b[19], b});
    return d[20] ? diff_t'(-d) : diff_t'(d);
  endfunction

endpackage

>>> hw/rtl/tspm_if.sv
interface tspm_in_if;
  import tspm_pkg::*;
  logic    valid;
  logic    ready;
  logic    mode;
  height_t height;
  modport source (output valid, output mode, output height, input ready);
  modport sink (input valid, input mode, input height, output ready);
endinterface

interface tspm_out_if;
  import tspm_pkg::*;
  logic   valid;
  logic   ready;
  slope_t slope;
  logic   passable;
  logic   end_of_map;
  modport source (output valid, output slope, output passable, output end_of_map,
                  input ready);
  modport sink (input valid, input slope, input passable, input end_of_map,
                output ready);
endinterface

>>> hw/rtl/tspm_ram.sv
module tspm_ram #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  output tspm_pkg::height_t rd_data_a_r,
  output tspm_pkg::height_t rd_data_b_r,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  tspm_pkg::height_t wr_data
);
  import tspm_pkg::*;

  height_t mem [DEPTH];

  // write-first: a read that meets a write to the same entry sees the new data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a_r <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
      rd_data_b_r <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
    end
  end

endmodule

>>> hw/rtl/tspm_ctrl.sv
module tspm_ctrl #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tspm_pkg::cfg_t        cfg,
  tspm_in_if.sink               in_ch,
  input  logic                  s1_ready,
  output logic                  rd_en,
  output logic [AW-1:0]         mid_addr_a,
  output logic [AW-1:0]         mid_addr_b,
  output logic [AW-1:0]         up_addr_a,
  output logic [AW-1:0]         up_addr_b,
  output logic                  s1_valid_r,
  output tspm_pkg::cell_ctl_t   s1_ctl_r,
  output logic [AW-1:0]         s1_col_r,
  output tspm_pkg::ctl_stat_t   stat
);
  import tspm_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int EW = (WW > 11) ? WW : 11;
  localparam int EH = (HW > 11) ? HW : 11;

  logic [AW-1:0] col_r, col_nxt, flush_r, flush_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic          s1_valid_nxt;

  logic [EW-1:0] w_ext, eff_w, c_ext, c_inc;
  logic [EH-1:0] h_ext, eff_h;
  logic [AW-1:0] c_samp, c_fl, c;
  logic          is_flush, row_lt_h, act, accept, fire, at_end;
  cell_ctl_t     ctl_nxt;

  always_comb begin
    w_ext = EW'(cfg.map_width);
    h_ext = EH'(cfg.map_height);
    eff_w = (w_ext == '0) ? EW'(1) : ((w_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_ext);
    eff_h = (h_ext == '0) ? EH'(1) : ((h_ext > EH'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : h_ext);
  end

  assign in_ch.ready = !s1_valid_r || s1_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_flush    = (in_ch.mode == MODE_FLUSH);
  assign row_lt_h    = EH'(row_r) < eff_h;
  assign act         = is_flush ? !row_lt_h : row_lt_h;
  assign fire        = accept && act;

  // a column past a shrunken width restarts a sample row, or ends a flush
  assign c_samp = (EW'(col_r) >= eff_w) ? '0 : col_r;
  assign c_fl   = (EW'(flush_r) >= eff_w) ? AW'(eff_w - EW'(1)) : flush_r;
  assign c      = is_flush ? c_fl : c_samp;
  assign c_ext  = EW'(c);
  assign c_inc  = c_ext + EW'(1);
  assign at_end = c_inc >= eff_w;

  always_comb begin
    ctl_nxt.emit      = is_flush || (row_r != '0);
    ctl_nxt.wr_mid    = !is_flush;
    ctl_nxt.has_left  = (c != '0);
    ctl_nxt.has_right = !at_end;
    ctl_nxt.has_up    = is_flush ? (eff_h >= EH'(2)) : (row_r >= HW'(2));
    ctl_nxt.has_down  = !is_flush;
    // flushed cells sit on the last row, which is border
    ctl_nxt.border    = is_flush || (row_r == HW'(1)) || (c == '0) || at_end;
    ctl_nxt.last      = is_flush && at_end;
    ctl_nxt.down      = in_ch.height;
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    flush_nxt = flush_r;
    if (fire) begin
      if (is_flush) begin
        if (at_end) begin
          col_nxt   = '0;
          row_nxt   = '0;
          flush_nxt = '0;
        end else begin
          flush_nxt = AW'(c_inc);
        end
      end else if (at_end) begin
        col_nxt = '0;
        row_nxt = row_r + HW'(1);
      end else begin
        col_nxt = AW'(c_inc);
      end
    end
  end

  assign s1_valid_nxt = fire ? 1'b1 : (s1_ready ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      flush_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      flush_r    <= flush_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_ctl_r <= ctl_nxt;
      s1_col_r <= c;
    end
  end

  assign rd_en      = fire;
  assign mid_addr_a = c;
  assign mid_addr_b = c + AW'(1);
  assign up_addr_a  = c - AW'(1);
  assign up_addr_b  = c;

  assign stat.last_fire = fire && ctl_nxt.last;
  assign stat.map_start = (row_r == '0) && (col_r == '0) && (flush_r == '0);

endmodule

>>> hw/rtl/tspm_slope.sv
module tspm_slope #(
  parameter int RES_SCALE = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tspm_pkg::cfg_t      cfg,
  input  logic                s1_valid,
  input  tspm_pkg::cell_ctl_t s1_ctl,
  input  tspm_pkg::height_t   ctr,
  input  tspm_pkg::height_t   right,
  input  tspm_pkg::height_t   left,
  input  tspm_pkg::height_t   up,
  output logic                s1_ready,
  tspm_out_if.source          out_ch
);
  import tspm_pkg::*;

  // floor(m * 6 / RES_SCALE) as one multiply by a scaled reciprocal
  localparam int DIV_SH = SCALED_W + $clog2(RES_SCALE);
  localparam longint unsigned RECIP = ((64'd1 << DIV_SH) + RES_SCALE - 1) / RES_SCALE;
  localparam longint unsigned MULT = SLOPE_FACTOR * RECIP;
  localparam int PW = DIV_SH + SCALED_W;

  logic    v2_r, v3_r, v4_r, vo_r;
  logic    rdy2, rdy3, rdy4, rdyo;

  diff_t   d2_r [4];
  height_t ctr2_r, ctr3_r, ctr4_r;
  logic    border2_r, border3_r, border4_r;
  logic    last2_r, last3_r, last4_r;
  diff_t   m3_r;
  logic [PW-1:0] prod4_r;

  slope_t  slope_o_r;
  logic    pass_o_r, eom_o_r;

  diff_t   d_nxt [4];
  diff_t   mx01, mx23, m_nxt;
  logic [PW-1:0] prod_nxt;
  logic [SCALED_W-1:0] q;
  slope_t  slope_nxt;
  logic signed [20:0] ctr_x, neg_max, neg_min;
  logic    pass_nxt;

  assign rdyo     = !vo_r || out_ch.ready;
  assign rdy4     = !v4_r || rdyo;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign s1_ready = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= s1_valid && s1_ctl.emit;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdyo) vo_r <= v4_r;
    end
  end

  // missing neighbors count as zero difference
  always_comb begin
    d_nxt[0] = s1_ctl.has_left  ? abs_diff(ctr, left)        : '0;
    d_nxt[1] = s1_ctl.has_right ? abs_diff(ctr, right)       : '0;
    d_nxt[2] = s1_ctl.has_up    ? abs_diff(ctr, up)          : '0;
    d_nxt[3] = s1_ctl.has_down  ? abs_diff(ctr, s1_ctl.down) : '0;
  end

  always_comb begin
    mx01  = (d2_r[0] > d2_r[1]) ? d2_r[0] : d2_r[1];
    mx23  = (d2_r[2] > d2_r[3]) ? d2_r[2] : d2_r[3];
    m_nxt = (mx01 > mx23) ? mx01 : mx23;
  end

  assign prod_nxt = PW'(m3_r) * PW'(MULT);

  // the scaled value cannot reach the 24-bit ceiling, so only the floor applies
  always_comb begin
    q         = prod4_r[DIV_SH +: SCALED_W];
    slope_nxt = (slope_t'(q) < SLOPE_MIN) ? SLOPE_MIN : slope_t'(q);
    ctr_x     = $signed({ctr4_r[19], ctr4_r});
    neg_max   = -$signed({cfg.max_depth[19], cfg.max_depth});
    neg_min   = -$signed({cfg.min_depth[19], cfg.min_depth});
    pass_nxt  = !border4_r && (slope_nxt <= cfg.slope_limit)
                && (ctr_x > neg_max) && (ctr_x < neg_min);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      d2_r      <= d_nxt;
      ctr2_r    <= ctr;
      border2_r <= s1_ctl.border;
      last2_r   <= s1_ctl.last;
    end
    if (rdy3) begin
      m3_r      <= m_nxt;
      ctr3_r    <= ctr2_r;
      border3_r <= border2_r;
      last3_r   <= last2_r;
    end
    if (rdy4) begin
      prod4_r   <= prod_nxt;
      ctr4_r    <= ctr3_r;
      border4_r <= border3_r;
      last4_r   <= last3_r;
    end
    if (rdyo) begin
      slope_o_r <= slope_nxt;
      pass_o_r  <= pass_nxt;
      eom_o_r   <= last4_r;
    end
  end

  assign out_ch.valid      = vo_r;
  assign out_ch.slope      = slope_o_r;
  assign out_ch.passable   = pass_o_r;
  assign out_ch.end_of_map = eom_o_r;

endmodule

>>> hw/rtl/terrain_slope_passability_map.sv
// channel   dir  handshake        payload
// in_ch     in   valid/ready      mode, height (signed Q15.4)
// out_ch    out  valid/ready      slope (Q.4), passable, end_of_map
// apb       in   psel/penable     paddr 4*i, pwdata/prdata 32 bit, pready tied high
//
// one transaction per cycle unless out_ch stalls; results pass the read and slope stages
// each transaction reads two row buffers at two ports each and writes one entry back
// into the upper one, and into the middle one for samples, with write-first bypass
// covering the neighbor written by the previous transaction; results trail by one row,
// and flush transactions drain the last row; synchronous active-low reset clears counters
// and pipeline valids and loads the config reset values; row buffers need no clearing
// a stalled out_ch backs up through a valid/ready pipeline, bubbles collapse
module terrain_slope_passability_map #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int RES_SCALE = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tspm_in_if.sink                              in_ch,
  tspm_out_if.source                           out_ch,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tspm_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [tspm_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [tspm_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import tspm_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  cfg_t      cfg_r, cfg_nxt;
  reg_idx_t  idx;
  logic      cfg_wr;

  logic          rd_en, s1_valid, s1_ready, u_we, m_we;
  logic [AW-1:0] mid_addr_a, mid_addr_b, up_addr_a, up_addr_b, s1_col;
  cell_ctl_t     s1_ctl;
  ctl_stat_t     stat;
  height_t       mid_a, mid_b, up_a, up_b;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (idx)
        REG_MAP_WIDTH:   cfg_nxt.map_width   = pwdata[10:0];
        REG_MAP_HEIGHT:  cfg_nxt.map_height  = pwdata[10:0];
        REG_SLOPE_LIMIT: cfg_nxt.slope_limit = pwdata[23:0];
        REG_MIN_DEPTH:   cfg_nxt.min_depth   = pwdata[19:0];
        REG_MAX_DEPTH:   cfg_nxt.max_depth   = pwdata[19:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAP_WIDTH:   prdata = CFG_DATA_W'(cfg_r.map_width);
      REG_MAP_HEIGHT:  prdata = CFG_DATA_W'(cfg_r.map_height);
      REG_SLOPE_LIMIT: prdata = CFG_DATA_W'(cfg_r.slope_limit);
      REG_MIN_DEPTH:   prdata = CFG_DATA_W'(signed'(cfg_r.min_depth));
      REG_MAX_DEPTH:   prdata = CFG_DATA_W'(signed'(cfg_r.max_depth));
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_width   <= MAP_WIDTH_RST;
      cfg_r.map_height  <= MAP_HEIGHT_RST;
      cfg_r.slope_limit <= SLOPE_LIMIT_RST;
      cfg_r.min_depth   <= MIN_DEPTH_RST;
      cfg_r.max_depth   <= MAX_DEPTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tspm_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .s1_ready   (s1_ready),
    .rd_en      (rd_en),
    .mid_addr_a (mid_addr_a),
    .mid_addr_b (mid_addr_b),
    .up_addr_a  (up_addr_a),
    .up_addr_b  (up_addr_b),
    .s1_valid_r (s1_valid),
    .s1_ctl_r   (s1_ctl),
    .s1_col_r   (s1_col),
    .stat       (stat)
  );

  // the upper row takes the old middle entry, the middle row the new sample
  assign u_we = s1_valid && s1_ready;
  assign m_we = u_we && s1_ctl.wr_mid;

  tspm_ram #(.DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk         (clk),
    .rd_en       (rd_en),
    .rd_addr_a   (mid_addr_a),
    .rd_addr_b   (mid_addr_b),
    .rd_data_a_r (mid_a),
    .rd_data_b_r (mid_b),
    .wr_en       (m_we),
    .wr_addr     (s1_col),
    .wr_data     (s1_ctl.down)
  );

  tspm_ram #(.DEPTH(MAX_WIDTH)) u_up_ram (
    .clk         (clk),
    .rd_en       (rd_en),
    .rd_addr_a   (up_addr_a),
    .rd_addr_b   (up_addr_b),
    .rd_data_a_r (up_a),
    .rd_data_b_r (up_b),
    .wr_en       (u_we),
    .wr_addr     (s1_col),
    .wr_data     (mid_a)
  );

  tspm_slope #(.RES_SCALE(RES_SCALE)) u_slope (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .ctr      (mid_a),
    .right    (mid_b),
    .left     (up_a),
    .up       (up_b),
    .s1_ready (s1_ready),
    .out_ch   (out_ch)
  );

  a_mid_with_up: assert property (@(posedge clk) disable iff (!rst_n)
    m_we |-> u_we)
    else $error("middle row written without upper row shift");

  a_map_restart: assert property (@(posedge clk) disable iff (!rst_n)
    stat.last_fire |=> stat.map_start)
    else $error("counters not cleared after final flush");

  a_eom_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.end_of_map |-> !out_ch.passable)
    else $error("final cell reported passable");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && !s1_ready |=> s1_valid)
    else $error("stalled cell lost from read stage");

endmodule
